>>> hdl/ssui_pkg.sv
// ----------------------------------------------------------------------------
// ssui_pkg
// Shared types and codes for the sorted set union / intersection block.
// ----------------------------------------------------------------------------
package ssui_pkg;

	localparam int DEF_SET_DEPTH   = 16;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int CMD_W    = 3;
	localparam int DATA_W   = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;
	localparam int OUT_W    = STATUS_W + DATA_W + COUNT_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_LOAD_A    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UNION     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INTERSECT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

	typedef enum logic [KIND_W-1:0] {
		KIND_STATUS  = 2'd0,
		KIND_ELEMENT = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_ORDER = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_CMP,
		S_SUM
	} state_t;

endpackage

>>> hdl/ssui_ram.sv
// ----------------------------------------------------------------------------
// ssui_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ssui_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/sorted_set_union_intersection.sv
// Load and clear: one beat accepted per cycle while the output is free; the status beat is registered
// and shows on the master side the cycle after acceptance.
// Union / intersection: a merge step is a store read (S_FETCH), then the shared comparator
// (S_CMP), which waits while an element is held at the output; once the run ends (union: both
// stores used up, intersection: either), S_SUM sends the count summary; input is held off.
// Reset clears the set counts and the sequencer; store contents are kept.
// ----------------------------------------------------------------------------
// sorted_set_union_intersection
// Two ascending sets held in RAM, merged by a sequencer around one comparator.
// ----------------------------------------------------------------------------
module sorted_set_union_intersection import ssui_pkg::*; #(
	parameter int SET_DEPTH   = DEF_SET_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,   // [31:0] value
	input  logic [CMD_W-1:0]       s_tuser,   // [2:0] command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] status, [33:2] element, [39:34] count
	output logic [KIND_W-1:0]      m_tuser,   // [1:0] kind
	output logic                   m_tlast
);

	localparam int VW = VALUE_WIDTH;
	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam int NW = $clog2(2 * SET_DEPTH + 1);

	state_t state_q, state_d;

	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic [CW-1:0] ia_q, ib_q;
	logic [NW-1:0] n_q;
	logic          uni_q;
	logic          have_q;
	logic [VW-1:0] prev_q;
	logic [VW-1:0] last_a_q, last_b_q;

	logic                m_valid_q;
	kind_t               kind_q;
	status_t             status_q;
	logic [DATA_W-1:0]   element_q;
	logic [COUNT_W-1:0]  count_q;
	logic                last_q;

	logic [VW-1:0] val_ext;
	logic [VW-1:0] rd_a, rd_b;
	logic          accept;
	logic          out_free;

	// shared comparator
	logic [VW-1:0] cmp_x, cmp_y;
	logic          cmp_lt, cmp_eq;

	// sequencer decisions
	logic          a_ok, b_ok, run_done;
	logic          take_a, take_b, match;
	logic [VW-1:0] cand;
	logic          emit, step;
	logic          ld_full, ld_order, ld_store, sel_b;
	logic          we_a, we_b;

	logic          out_load;
	kind_t         out_kind;
	status_t       out_status;
	logic [VW-1:0] out_elem_v;
	logic [DATA_W-1:0] out_elem;
	logic          out_last;

	generate
		if (VW > DATA_W) begin : g_wide
			assign val_ext  = {{(VW - DATA_W){s_tdata[DATA_W-1]}}, s_tdata};
			assign out_elem = out_elem_v[DATA_W-1:0];
		end else if (VW == DATA_W) begin : g_same
			assign val_ext  = s_tdata;
			assign out_elem = out_elem_v;
		end else begin : g_narrow
			assign val_ext  = s_tdata[VW-1:0];
			assign out_elem = {{(DATA_W - VW){out_elem_v[VW-1]}}, out_elem_v};
		end
	endgenerate

	ssui_ram #(.WIDTH(VW), .DEPTH(SET_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata (val_ext),
		.raddr (ia_q[AW-1:0]),
		.rdata (rd_a)
	);

	ssui_ram #(.WIDTH(VW), .DEPTH(SET_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata (val_ext),
		.raddr (ib_q[AW-1:0]),
		.rdata (rd_b)
	);

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign cmp_lt = $signed(cmp_x) < $signed(cmp_y);
	assign cmp_eq = cmp_x == cmp_y;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (s_tuser == CMD_UNION || s_tuser == CMD_INTERSECT)) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: state_d = S_CMP;
			S_CMP: begin
				if (run_done) begin
					state_d = S_SUM;
				end else if (step) begin
					state_d = S_FETCH;
				end
			end
			S_SUM: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		sel_b    = (s_tuser == CMD_LOAD_B);
		a_ok     = ia_q < cnt_a_q;
		b_ok     = ib_q < cnt_b_q;
		cmp_x    = val_ext;
		cmp_y    = sel_b ? last_b_q : last_a_q;
		if (state_q == S_CMP) begin
			cmp_x = rd_a;
			cmp_y = rd_b;
		end

		ld_full  = sel_b ? (cnt_b_q >= CW'(SET_DEPTH)) : (cnt_a_q >= CW'(SET_DEPTH));
		ld_order = !ld_full && ((sel_b ? cnt_b_q : cnt_a_q) != '0) && cmp_lt;
		ld_store = !ld_full && !ld_order;

		take_a = 1'b0;
		take_b = 1'b0;
		match  = 1'b0;
		cand   = rd_b;
		if (a_ok && b_ok) begin
			priority if (cmp_lt) begin
				take_a = 1'b1;
				cand   = rd_a;
			end else if (cmp_eq) begin
				take_a = 1'b1;
				take_b = 1'b1;
				match  = 1'b1;
				cand   = rd_a;
			end else begin
				take_b = 1'b1;
			end
		end else if (a_ok) begin
			take_a = 1'b1;
			cand   = rd_a;
		end else begin
			take_b = 1'b1;
		end
		run_done = uni_q ? (!a_ok && !b_ok) : !(a_ok && b_ok);
		// drop a repeat of the value just emitted
		emit     = (uni_q || match) && !(have_q && prev_q == cand);
		step     = (state_q == S_CMP) && !run_done && (!emit || out_free);

		we_a       = 1'b0;
		we_b       = 1'b0;
		out_load   = 1'b0;
		out_kind   = KIND_STATUS;
		out_status = STAT_OK;
		out_elem_v = '0;
		out_last   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (s_tuser)
						CMD_LOAD_A, CMD_LOAD_B: begin
							we_a     = ld_store && !sel_b;
							we_b     = ld_store && sel_b;
							out_load = 1'b1;
							out_last = 1'b1;
							priority if (ld_full) begin
								out_status = STAT_FULL;
							end else if (ld_order) begin
								out_status = STAT_ORDER;
							end else begin
								out_status = STAT_OK;
							end
						end
						CMD_CLEAR: begin
							out_load = 1'b1;
							out_last = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_CMP: begin
				if (step && emit) begin
					out_load   = 1'b1;
					out_kind   = KIND_ELEMENT;
					out_elem_v = cand;
				end
			end
			S_SUM: begin
				if (out_free) begin
					out_load = 1'b1;
					out_kind = KIND_SUMMARY;
					out_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			have_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we_a) begin
				cnt_a_q <= cnt_a_q + 1'b1;
			end
			if (we_b) begin
				cnt_b_q <= cnt_b_q + 1'b1;
			end
			if (accept && s_tuser == CMD_CLEAR) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
			end
			if (state_q == S_IDLE) begin
				have_q <= 1'b0;
			end else if (step && emit) begin
				have_q <= 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (we_a) begin
			last_a_q <= val_ext;
		end
		if (we_b) begin
			last_b_q <= val_ext;
		end
		if (state_q == S_IDLE) begin
			ia_q  <= '0;
			ib_q  <= '0;
			n_q   <= '0;
			uni_q <= (s_tuser == CMD_UNION);
		end else if (step) begin
			if (take_a) begin
				ia_q <= ia_q + 1'b1;
			end
			if (take_b) begin
				ib_q <= ib_q + 1'b1;
			end
			if (emit) begin
				n_q    <= n_q + 1'b1;
				prev_q <= cand;
			end
		end
		if (out_load) begin
			kind_q    <= out_kind;
			status_q  <= out_status;
			element_q <= out_elem;
			count_q   <= (out_kind == KIND_SUMMARY) ? COUNT_W'(n_q) : '0;
			last_q    <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = OUT_TDATA_W'({count_q, element_q, status_q});

endmodule
